// ===== hw/rtl/lfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpp_pkg
// Types and codes shared by the LED flash pattern player.
// ----------------------------------------------------------------------------
package lfpp_pkg;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_ON     = 3'd1,
        REQ_OFF    = 3'd2,
        REQ_BRIGHT = 3'd3,
        REQ_WORD   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_FLASH = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] brightness_value;
        logic        has_brightness;
        logic [15:0] duration_ms;
        logic        last_word;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] duty;
        logic [1:0] led_mode;
        logic       pattern_overflow;
    } t_out_beat;

endpackage

// ===== hw/rtl/led_flash_pattern_player.sv =====
// ----------------------------------------------------------------------------
// led_flash_pattern_player
// Drives one LED duty value: off, steady on, or a looping flash pattern.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, payload i_in_data) carries one
// request per beat: a 1 ms tick, turn on, turn off, set brightness or one
// pattern word. Every accepted beat gives exactly one result beat on the
// output channel (o_out_valid / i_out_ready, payload o_out_data) holding the
// duty, the mode and the overflow flag for that request.
// The result is registered: it is in the output register at the edge after
// acceptance. Throughput is one beat per cycle when the output is not held;
// the state update and the pattern store read for the next entry both fit in
// that cycle, the store read being registered ahead from the next play index.
// When the receiver stalls, the output register holds its beat and a new
// beat is taken only in a cycle where that register empties, so the input
// is stalled at most as long as the output.
// Reset clears the mode to off, the duty to zero, brightness to zero and
// the polarity to active high; the pattern store is not cleared.
// i_cfg_we writes the polarity bit; a change inverts the held duty at once.
// ----------------------------------------------------------------------------
module led_flash_pattern_player
    import lfpp_pkg::*;
#(
    parameter int PATTERN_DEPTH = 16,
    parameter int PWM_BITS      = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int IW = $clog2(PATTERN_DEPTH);
    localparam int LW = $clog2(PATTERN_DEPTH + 1);
    localparam int DW = (PWM_BITS > 8) ? PWM_BITS : 8;
    localparam logic [PWM_BITS-1:0] MAX_DUTY = '1;
    localparam logic [LW-1:0] DEPTH_L = LW'(PATTERN_DEPTH);

    logic [15:0] r_store [PATTERN_DEPTH];
    logic [15:0] r_rd_dur;
    logic [15:0] r_first_dur, n_first_dur;

    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_load, n_load;
    logic [IW-1:0]       r_play, n_play;
    logic [15:0]         r_rem, n_rem;
    logic [PWM_BITS-1:0] r_bright, n_bright;
    t_mode               r_mode, n_mode;
    logic [PWM_BITS-1:0] r_duty, n_duty;
    logic                r_active, n_active;
    logic                r_out_valid;
    t_out_beat           r_out_data, n_out_data;

    logic                accept;
    logic                ovf;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       tick_next;
    logic [15:0]         rem_dec;
    logic [15:0]         first_dur;
    logic [LW-1:0]       len_now;
    logic [PWM_BITS-1:0] sat_val;
    logic [DW-1:0]       duty_ext;

    function automatic logic [PWM_BITS-1:0] polar(input logic act,
                                                  input logic [PWM_BITS-1:0] lvl);
        return act ? lvl : ~lvl;
    endfunction

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] inc;
        inc = LW'(idx) + LW'(1);
        return (inc >= len) ? '0 : inc[IW-1:0];
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign sat_val    = (i_in_data.brightness_value > 16'(MAX_DUTY))
                      ? MAX_DUTY : i_in_data.brightness_value[PWM_BITS-1:0];
    assign tick_next  = next_idx(r_play, r_len);
    assign rem_dec    = (r_rem != 16'd0) ? r_rem - 16'd1 : 16'd0;

    always_comb begin
        n_len       = r_len;
        n_load      = r_load;
        n_play      = r_play;
        n_rem       = r_rem;
        n_bright    = r_bright;
        n_mode      = r_mode;
        n_duty      = r_duty;
        n_active    = r_active;
        n_first_dur = r_first_dur;
        ovf         = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_load[IW-1:0];
        first_dur   = r_first_dur;
        len_now     = r_load;

        if (accept) begin
            unique case (t_req'(i_in_data.req_type))
                REQ_TICK: begin
                    if (r_mode == MODE_FLASH) begin
                        n_rem = rem_dec;
                        if (rem_dec == 16'd0) begin
                            n_play = tick_next;
                            n_rem  = (r_rd_dur == 16'd0) ? 16'd1 : r_rd_dur;
                            n_duty = tick_next[0] ? polar(r_active, r_bright)
                                                  : polar(r_active, '0);
                        end
                    end
                end
                REQ_ON: begin
                    if (i_in_data.has_brightness) begin
                        n_bright = sat_val;
                    end
                    n_len  = '0;
                    n_load = '0;
                    n_play = '0;
                    n_rem  = '0;
                    n_mode = MODE_ON;
                    n_duty = polar(r_active, n_bright);
                end
                REQ_OFF: begin
                    n_len  = '0;
                    n_load = '0;
                    n_play = '0;
                    n_rem  = '0;
                    n_mode = MODE_OFF;
                    n_duty = polar(r_active, '0);
                end
                REQ_BRIGHT: begin
                    n_bright = sat_val;
                    if (r_mode == MODE_ON) begin
                        n_duty = polar(r_active, sat_val);
                    end
                end
                REQ_WORD: begin
                    if (i_in_data.has_brightness) begin
                        n_bright = sat_val;
                    end
                    if (r_load == '0) begin
                        n_len       = '0;
                        n_play      = '0;
                        n_rem       = '0;
                        n_mode      = MODE_OFF;
                        n_duty      = polar(r_active, '0);
                        n_first_dur = i_in_data.duration_ms;
                        first_dur   = i_in_data.duration_ms;
                    end
                    if (r_load < DEPTH_L) begin
                        wr_en   = 1'b1;
                        len_now = r_load + LW'(1);
                    end else begin
                        ovf = 1'b1;
                    end
                    n_load = len_now;
                    if (i_in_data.last_word) begin
                        n_load = '0;
                        if (len_now == LW'(1) && first_dur != 16'd0) begin
                            n_len  = '0;
                            n_play = '0;
                            n_rem  = '0;
                            n_mode = MODE_ON;
                            n_duty = polar(r_active, n_bright);
                        end else begin
                            n_len  = len_now;
                            n_mode = MODE_FLASH;
                            n_play = '0;
                            n_rem  = (first_dur == 16'd0) ? 16'd1 : first_dur;
                            n_duty = polar(r_active, '0);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cfg_we) begin
            n_active = i_cfg_data;
            if (i_cfg_data != r_active) begin
                n_duty = ~n_duty;
            end
        end
    end

    // prefetch duration of the entry after the next play index
    assign rd_addr = next_idx(n_play, n_len);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_in_data.duration_ms;
        end
        if (wr_en && wr_addr == rd_addr) begin
            r_rd_dur <= i_in_data.duration_ms;
        end else begin
            r_rd_dur <= r_store[rd_addr];
        end
    end

    assign duty_ext = DW'(n_duty);

    always_comb begin
        n_out_data.duty             = duty_ext[7:0];
        n_out_data.led_mode         = n_mode;
        n_out_data.pattern_overflow = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_load      <= '0;
            r_play      <= '0;
            r_rem       <= '0;
            r_bright    <= '0;
            r_mode      <= MODE_OFF;
            r_duty      <= '0;
            r_active    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_load   <= n_load;
            r_play   <= n_play;
            r_rem    <= n_rem;
            r_bright <= n_bright;
            r_mode   <= n_mode;
            r_duty   <= n_duty;
            r_active <= n_active;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_dur <= n_first_dur;
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_flash_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FLASH |-> r_len != '0)
        else $error("flashing with empty pattern");

    a_flash_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FLASH |-> r_rem != 16'd0)
        else $error("flashing entry with no time left");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load <= DEPTH_L && r_len <= DEPTH_L)
        else $error("pattern count beyond store depth");

    a_play_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FLASH |-> LW'(r_play) < r_len)
        else $error("play index outside pattern");
`endif

endmodule

// ===== dv/led_flash_pattern_player_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_flash_pattern_player_test
// Self-checking bench for the LED flash pattern player. Requests go in on a
// valid/ready channel and each accepted beat is run through a duty predictor
// kept in a small scoreboard class; every result beat is checked field by
// field against the oldest prediction. A short directed run covers the
// saturation limits, every request kind, single-entry patterns and unused
// codes, then four random phases of pattern loads, tick bursts and commands
// run under different sender and receiver idling, with a polarity write
// before each phase.
// ----------------------------------------------------------------------------
module led_flash_pattern_player_test;
    import lfpp_pkg::*;

    localparam int         DEPTH       = 16;
    localparam logic [7:0] FULL_DUTY   = 8'hFF;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 80;
    localparam int         PHASE_ITEMS = 320;

    class lfpp_duty_board;
        logic [15:0] pat_store [DEPTH];
        logic [4:0]  pat_len;
        logic [4:0]  load_cnt;
        logic [3:0]  play_idx;
        logic [15:0] remain_ms;
        logic [7:0]  bright;
        logic [7:0]  duty;
        t_mode       mode;
        logic        act_high;
        t_out_beat   due_q [$];
        int          errors;

        function new();
            foreach (pat_store[i]) pat_store[i] = '0;
            act_high = 1'b1;
            bright   = '0;
            errors   = 0;
            go_idle(MODE_OFF);
        endfunction

        function logic [7:0] polar(input logic [7:0] level);
            return act_high ? level : FULL_DUTY - level;
        endfunction

        function logic [7:0] clip(input logic [15:0] v);
            return (v > FULL_DUTY) ? FULL_DUTY : v[7:0];
        endfunction

        function void go_idle(input t_mode m);
            pat_len   = '0;
            load_cnt  = '0;
            play_idx  = '0;
            remain_ms = '0;
            mode      = m;
            duty      = (m == MODE_ON) ? polar(bright) : polar(8'd0);
        endfunction

        function void open_entry(input logic [3:0] idx);
            play_idx  = idx;
            remain_ms = (pat_store[idx] == 16'd0) ? 16'd1 : pat_store[idx];
            duty      = idx[0] ? polar(bright) : polar(8'd0);
        endfunction

        function void write_polarity(input logic v);
            if (v != act_high)
                duty = FULL_DUTY - duty;
            act_high = v;
        endfunction

        function void take_request(input t_in_beat b);
            logic [4:0] nxt;
            logic [4:0] len;
            t_out_beat  want;
            logic       ovf;
            ovf = 1'b0;
            case (b.req_type)
                REQ_TICK: begin
                    if (mode == MODE_FLASH && pat_len != 0) begin
                        if (remain_ms != 0)
                            remain_ms = remain_ms - 16'd1;
                        if (remain_ms == 0) begin
                            nxt = {1'b0, play_idx} + 5'd1;
                            if (nxt >= pat_len)
                                nxt = '0;
                            open_entry(nxt[3:0]);
                        end
                    end
                end
                REQ_ON: begin
                    if (b.has_brightness)
                        bright = clip(b.brightness_value);
                    go_idle(MODE_ON);
                end
                REQ_OFF: go_idle(MODE_OFF);
                REQ_BRIGHT: begin
                    bright = clip(b.brightness_value);
                    if (mode == MODE_ON)
                        duty = polar(bright);
                end
                REQ_WORD: begin
                    if (b.has_brightness)
                        bright = clip(b.brightness_value);
                    if (load_cnt == 0)
                        go_idle(MODE_OFF);
                    if (load_cnt < DEPTH) begin
                        pat_store[load_cnt[3:0]] = b.duration_ms;
                        load_cnt = load_cnt + 5'd1;
                    end else begin
                        ovf = 1'b1;
                    end
                    if (b.last_word) begin
                        len      = load_cnt;
                        load_cnt = '0;
                        if (len == 1 && pat_store[0] != 0) begin
                            go_idle(MODE_ON);
                        end else if (len != 0) begin
                            pat_len = len;
                            mode    = MODE_FLASH;
                            open_entry(4'd0);
                        end
                    end
                end
                default: ;
            endcase
            want.duty             = duty;
            want.led_mode         = mode;
            want.pattern_overflow = ovf;
            due_q.push_back(want);
        endfunction

        function void match_result(input t_out_beat got);
            t_out_beat want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: duty %0d mode %0d overflow %0b",
                             got.duty, got.led_mode, got.pattern_overflow);
                return;
            end
            want = due_q.pop_front();
            if (got.duty !== want.duty || got.led_mode !== want.led_mode ||
                got.pattern_overflow !== want.pattern_overflow) begin
                errors++;
                if (errors <= 10)
                    $display({"result mismatch: duty %0d/%0d mode %0d/%0d ",
                              "overflow %0b/%0b (exp/got)"},
                             want.duty, got.duty, want.led_mode, got.led_mode,
                             want.pattern_overflow, got.pattern_overflow);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b1;
    logic      req_valid = 1'b0;
    logic      req_ready;
    t_in_beat  req_beat  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    t_out_beat res_beat;

    lfpp_duty_board board;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        req_count = 0;
    int        cycle_cnt = 0;
    logic      hold_ask = 1'b0;

    led_flash_pattern_player dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_beat),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_beat)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("led_flash_pattern_player_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            board.match_result(res_beat);
    end

    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else begin
                res_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic logic [15:0] pick_bright();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(255));
            1:       return 16'($urandom_range(65535));
            2:       return 16'($urandom_range(250, 260));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_duration();
        return ($urandom_range(19) == 0) ? 16'($urandom_range(65535))
                                         : 16'($urandom_range(4));
    endfunction

    task automatic offer_request(input logic [2:0] req, input logic [15:0] bval,
                                 input logic hasb, input logic [15:0] dur,
                                 input logic last);
        t_in_beat b;
        b.req_type         = req;
        b.brightness_value = bval;
        b.has_brightness   = hasb;
        b.duration_ms      = dur;
        b.last_word        = last;
        while ($urandom_range(99) < src_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= b;
        do @(posedge clk); while (!req_ready);
        board.take_request(b);
        if (req <= REQ_WORD)
            req_count++;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (board.due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_polarity(input logic v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_polarity(v);
    endtask

    task automatic tick_burst(input int n);
        repeat (n)
            offer_request(REQ_TICK, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    task automatic random_chunk();
        int   pick;
        int   len;
        int   k;
        logic cut;
        pick = $urandom_range(99);
        if (pick < 45) begin
            len = ($urandom_range(5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
            cut = ($urandom_range(9) == 0);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(11) == 0)
                    tick_burst(1);
                offer_request(REQ_WORD, pick_bright(), ($urandom_range(7) == 0),
                              pick_duration(), (k == len - 1) && !cut);
            end
            tick_burst($urandom_range(3, 30));
        end else if (pick < 60) begin
            tick_burst($urandom_range(1, 20));
        end else if (pick < 75) begin
            offer_request(REQ_ON, pick_bright(), 1'($urandom_range(1)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
        end else if (pick < 85) begin
            offer_request(REQ_OFF, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
        end else if (pick < 93) begin
            offer_request(REQ_BRIGHT, pick_bright(), 1'($urandom_range(1)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
        end else begin
            offer_request(3'($urandom_range(7)), 16'($urandom_range(65535)),
                          1'($urandom_range(1)), 16'($urandom_range(65535)),
                          1'($urandom_range(1)));
        end
    endtask

    task automatic directed_run();
        offer_request(REQ_TICK, 16'd0, 1'b0, 16'd0, 1'b0);
        offer_request(REQ_BRIGHT, 16'hFFFF, 1'b0, 16'd0, 1'b0);
        offer_request(REQ_ON, 16'd0, 1'b0, 16'd0, 1'b0);
        offer_request(REQ_BRIGHT, 16'd0, 1'b0, 16'd0, 1'b0);
        offer_request(REQ_ON, 16'd256, 1'b1, 16'd0, 1'b0);
        offer_request(REQ_BRIGHT, 16'd100, 1'b0, 16'hFFFF, 1'b1);
        offer_request(REQ_OFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        offer_request(3'd5, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        offer_request(3'd7, 16'd0, 1'b0, 16'd0, 1'b0);
        // single non-zero entry gives steady on
        offer_request(REQ_WORD, 16'd200, 1'b1, 16'd3, 1'b1);
        // single zero entry flashes
        offer_request(REQ_WORD, 16'd0, 1'b0, 16'd0, 1'b1);
        tick_burst(2);
        offer_request(REQ_WORD, 16'd0, 1'b0, 16'd1, 1'b0);
        offer_request(REQ_WORD, 16'd0, 1'b0, 16'd0, 1'b0);
        offer_request(REQ_WORD, 16'd255, 1'b1, 16'd2, 1'b1);
        tick_burst(4);
        offer_request(REQ_BRIGHT, 16'd77, 1'b0, 16'd0, 1'b0);
        tick_burst(3);
        // load cut short by turn on
        offer_request(REQ_WORD, 16'd0, 1'b0, 16'hFFFF, 1'b0);
        offer_request(REQ_ON, 16'd0, 1'b0, 16'd0, 1'b0);
        tick_burst(1);
    endtask

    initial begin : stimulus
        int ph;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_polarity(1'b1);
        directed_run();
        for (ph = 0; ph < 4; ph++) begin
            set_polarity(ph[0]);
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
                default: begin src_idle_pct = 8; snk_stall_pct = 8; end
            endcase
            if (ph == 0)
                hold_ask = 1'b1;
            req_count = 0;
            while (req_count < PHASE_ITEMS)
                random_chunk();
        end
        settle();
        if (board.errors == 0 && board.due_q.size() == 0)
            $display("led_flash_pattern_player_test: PASS");
        else
            $display("led_flash_pattern_player_test: FAIL");
        $finish;
    end

endmodule

// ===== led_flash_pattern_player.f =====
hw/rtl/lfpp_pkg.sv
hw/rtl/led_flash_pattern_player.sv
dv/led_flash_pattern_player_test.sv
